// File: rtl/r2e_pkg.sv
// Package for the rotation-to-Euler block: payload structs, CORDIC angle table,
// and fixed-point constants. No dependencies.
package r2e_pkg;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r10;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
    } r2e_in_t;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic               is_singular;
    } r2e_out_t;

    localparam int ANG_W     = 35;   // radians * 2^30, with headroom
    localparam int VEC_W     = 34;   // CORDIC x/y width after prescale and growth
    localparam int SUMSQ_W   = 32;   // r00^2 + r10^2
    localparam int SY_W      = 16;   // floor sqrt of SUMSQ_W bits
    localparam int MAX_STEPS = 24;
    localparam int OUT_LIMIT = 25736;

    localparam logic signed [ANG_W-1:0] ANG_PI = 35'sd3373259426;

    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 35'sd843314857;
                5'd1:    v = 35'sd497837829;
                5'd2:    v = 35'sd263043837;
                5'd3:    v = 35'sd133525159;
                5'd4:    v = 35'sd67021687;
                5'd5:    v = 35'sd33543516;
                5'd6:    v = 35'sd16775851;
                5'd7:    v = 35'sd8388437;
                5'd8:    v = 35'sd4194283;
                5'd9:    v = 35'sd2097149;
                5'd10:   v = 35'sd1048576;
                5'd11:   v = 35'sd524288;
                5'd12:   v = 35'sd262144;
                5'd13:   v = 35'sd131072;
                5'd14:   v = 35'sd65536;
                5'd15:   v = 35'sd32768;
                5'd16:   v = 35'sd16384;
                5'd17:   v = 35'sd8192;
                5'd18:   v = 35'sd4096;
                5'd19:   v = 35'sd2048;
                5'd20:   v = 35'sd1024;
                5'd21:   v = 35'sd512;
                5'd22:   v = 35'sd256;
                5'd23:   v = 35'sd128;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } r2e_cvec_t;

endpackage

// File: rtl/r2e_isqrt.sv
// Pipelined restoring square root of r00^2 + r10^2, one result bit per stage.
// Depends on r2e_pkg.
module r2e_isqrt
    import r2e_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [15:0]       a,
    input  logic signed [15:0]       b,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic [SY_W-1:0]          sy,
    output logic [SIDE_W-1:0]        out_side
);

    localparam int NST = SY_W;

    logic [NST:0]              v_reg;
    logic [SUMSQ_W-1:0]        rem_reg  [NST+1];
    logic [SY_W-1:0]           root_reg [NST+1];
    logic [SIDE_W-1:0]         side_reg [NST+1];
    logic signed [31:0]        pa;
    logic signed [31:0]        pb;

    assign pa = a * a;
    assign pb = b * b;

    // stage 0: squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= SUMSQ_W'($unsigned(pa)) + SUMSQ_W'($unsigned(pb));
        root_reg[0] <= '0;
        side_reg[0] <= in_side;
    end

    // digit stages: test bit (NST-1-k), most significant first
    for (genvar k = 0; k < NST; k++) begin : g_dig
        localparam int BIT = NST - 1 - k;
        logic [SY_W-1:0]    trial;
        logic [SUMSQ_W:0]   tsq;
        logic               take;
        // square of trial compared against the whole value
        assign trial = root_reg[k] | (SY_W'(1) << BIT);
        assign tsq   = (SUMSQ_W+1)'(trial) * (SUMSQ_W+1)'(trial);
        assign take  = tsq <= {1'b0, rem_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_reg[k];
            root_reg[k+1] <= take ? trial : root_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = v_reg[NST];
    assign sy        = root_reg[NST];
    assign out_side  = side_reg[NST];

endmodule

// File: rtl/r2e_cordic.sv
// Pipelined vectoring CORDIC atan2: quadrant prestage, STEPS rotation stages (at most MAX_STEPS),
// and a rounding/saturation stage. Depends on r2e_pkg.
module r2e_cordic
    import r2e_pkg::*;
#(
    parameter int STEPS = 14
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [17:0]  y_in,
    input  logic signed [17:0]  x_in,
    output logic                out_valid,
    output logic signed [15:0]  angle
);

    localparam int NS = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;

    logic [NS+1:0]   v_reg;
    r2e_cvec_t       st_reg [NS+1];
    r2e_cvec_t       pre;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    logic signed [15:0]      ang_reg;

    // prescale and fold into the right half plane
    always_comb
    begin
        xs       = VEC_W'(x_in) <<< 12;
        ys       = VEC_W'(y_in) <<< 12;
        pre.zero = (x_in == '0) && (y_in == '0);
        if (x_in < 0)
        begin
            pre.x = -xs;
            pre.y = -ys;
            pre.z = (y_in >= 0) ? ANG_PI : -ANG_PI;
        end
        else
        begin
            pre.x = xs;
            pre.y = ys;
            pre.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= pre;
    end

    // rotation stages
    for (genvar i = 0; i < NS; i++) begin : g_rot
        r2e_cvec_t nxt;
        always_comb
        begin
            nxt.zero = st_reg[i].zero;
            if (st_reg[i].y >= 0)
            begin
                nxt.x = st_reg[i].x + (st_reg[i].y >>> i);
                nxt.y = st_reg[i].y - (st_reg[i].x >>> i);
                nxt.z = st_reg[i].z + atan_lut(5'(i));
            end
            else
            begin
                nxt.x = st_reg[i].x - (st_reg[i].y >>> i);
                nxt.y = st_reg[i].y + (st_reg[i].x >>> i);
                nxt.z = st_reg[i].z - atan_lut(5'(i));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            st_reg[i+1] <= nxt;
        end
    end

    // round to Q3.13 and saturate
    logic signed [ANG_W-1:0] zr;
    logic signed [ANG_W-1:0] lim;
    logic signed [15:0]      ang_next;
    always_comb
    begin
        zr  = (st_reg[NS].z + ANG_W'(65536)) >>> 17;
        lim = ANG_W'(OUT_LIMIT);
        if (st_reg[NS].zero)
            ang_next = '0;
        else if (zr > lim)
            ang_next = 16'(OUT_LIMIT);
        else if (zr < -lim)
            ang_next = -16'(OUT_LIMIT);
        else
            ang_next = 16'(zr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[NS+1] <= 1'b0;
        else
            v_reg[NS+1] <= v_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ang_next;
    end

    assign out_valid = v_reg[NS+1];
    assign angle     = ang_reg;

endmodule

// File: rtl/rotation_to_euler_angles.sv
// Rotation matrix to Z-Y-X Euler angles, fully pipelined.
// Path: a squares stage and 16 root-digit stages, then per CORDIC the fold,
// rotation and rounding stages, then one output register.
// Throughput: one transaction per cycle; busy is always low, no stalls.
// Reset: asynchronous active low; clears valid bits, threshold returns to 1.
// Depends on r2e_pkg, r2e_isqrt, r2e_cordic.
module rotation_to_euler_angles
    import r2e_pkg::*;
#(
    parameter int CORDIC_STEPS = 14
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  r2e_in_t     in_data,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    output logic        done,
    output r2e_out_t    out_data
);

    localparam int SIDE_W = 5 * 16;

    logic [14:0]        thresh_reg;
    logic               sq_valid;
    logic [SY_W-1:0]    sy;
    logic [SIDE_W-1:0]  side_in;
    logic [SIDE_W-1:0]  side_out;
    logic signed [15:0] d_r20, d_r21, d_r22, d_r11, d_r12;
    logic               sing;
    logic               sing_reg [CORDIC_STEPS+2];
    logic               vx, vy, vz;
    logic signed [15:0] ax, ay, az;
    logic               done_reg;
    r2e_out_t           out_reg;
    logic signed [17:0] xy, xx, zy, zx;

    assign busy = 1'b0;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= 15'd1;
        else if (cfg_we)
            thresh_reg <= cfg_wdata;
    end

    assign side_in = {in_data.r20, in_data.r21, in_data.r22, in_data.r11, in_data.r12};

    r2e_isqrt #(.SIDE_W(SIDE_W)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .in_valid(start),
        .a(in_data.r00), .b(in_data.r10), .in_side(side_in),
        .out_valid(sq_valid), .sy(sy), .out_side(side_out)
    );

    // r00/r10 are delayed in parallel for the yaw path
    logic signed [15:0] r00_d [17];
    logic signed [15:0] r10_d [17];
    always_ff @(posedge clk)
    begin
        r00_d[0] <= in_data.r00;
        r10_d[0] <= in_data.r10;
        for (int k = 1; k < 17; k++)
        begin
            r00_d[k] <= r00_d[k-1];
            r10_d[k] <= r10_d[k-1];
        end
    end

    assign {d_r20, d_r21, d_r22, d_r11, d_r12} = side_out;
    assign sing = {1'b0, sy} < {2'b0, thresh_reg};

    // operand selection for roll and yaw
    always_comb
    begin
        if (sing)
        begin
            xy = -18'(d_r12);
            xx = 18'(d_r11);
            zy = '0;
            zx = '0;
        end
        else
        begin
            xy = 18'(d_r21);
            xx = 18'(d_r22);
            zy = 18'(r10_d[16]);
            zx = 18'(r00_d[16]);
        end
    end

    r2e_cordic #(.STEPS(CORDIC_STEPS)) u_cx (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_valid),
        .y_in(xy), .x_in(xx), .out_valid(vx), .angle(ax)
    );
    r2e_cordic #(.STEPS(CORDIC_STEPS)) u_cy (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_valid),
        .y_in(-18'(d_r20)), .x_in(18'(sy)), .out_valid(vy), .angle(ay)
    );
    r2e_cordic #(.STEPS(CORDIC_STEPS)) u_cz (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_valid),
        .y_in(zy), .x_in(zx), .out_valid(vz), .angle(az)
    );

    // singular flag delay matching the CORDIC depth
    always_ff @(posedge clk)
    begin
        sing_reg[0] <= sing;
        for (int k = 1; k < CORDIC_STEPS + 2; k++)
            sing_reg[k] <= sing_reg[k-1];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vx & vy & vz;
    end

    always_ff @(posedge clk)
    begin
        out_reg.angle_x     <= ax;
        out_reg.angle_y     <= ay;
        out_reg.angle_z     <= az;
        out_reg.is_singular <= sing_reg[CORDIC_STEPS+1];
    end

    assign done     = done_reg;
    assign out_data = out_reg;

endmodule

// File: sim/tb_rotation_to_euler_angles.sv
// Testbench for rotation_to_euler_angles: drives random and corner-case rotation matrices,
// predicts the Euler angles in fixed point and checks every result. Depends on r2e_pkg.
`timescale 1ns / 100ps

module tb_rotation_to_euler_angles;
    import r2e_pkg::*;

    localparam int STEPS     = 14;
    localparam int LATENCY   = 40;
    localparam int N_RANDOM  = 1550;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    r2e_in_t     in_data;
    logic        cfg_we;
    logic [14:0] cfg_wdata;
    logic        done;
    r2e_out_t    out_data;

    rotation_to_euler_angles #(.CORDIC_STEPS(STEPS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Angle table, radians * 2^30
    longint atan_rad[14] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149,
                             1048576, 524288, 262144, 131072};

    r2e_in_t  matrix_q[$];
    r2e_out_t angles_q[$];
    logic [14:0] threshold;
    int errors;
    int n_checked;
    int n_singular;
    int burst_left;
    int gap_left;
    bit driving_on;

    // Vectoring CORDIC atan2, Q3.13 result
    function automatic longint cordic_atan2(longint yi, longint xi);
        longint x, y, z, dx, dy, r;
        begin
            if (xi == 0 && yi == 0)
                return 0;
            x = xi * 4096;
            y = yi * 4096;
            z = 0;
            if (x < 0)
            begin
                z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x += dx;
                    y -= dy;
                    z += atan_rad[i];
                end
                else
                begin
                    x -= dx;
                    y += dy;
                    z -= atan_rad[i];
                end
            end
            r = (z + 65536) >>> 17;
            if (r > OUT_LIMIT)
                r = OUT_LIMIT;
            if (r < -OUT_LIMIT)
                r = -OUT_LIMIT;
            return r;
        end
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint res, b;
        begin
            res = 0;
            b = 64'sd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        end
    endfunction

    function automatic r2e_out_t predict_angles(r2e_in_t m, logic [14:0] thr);
        r2e_out_t o;
        longint a00, a10, sy;
        begin
            a00 = m.r00;
            a10 = m.r10;
            sy = floor_sqrt(a00 * a00 + a10 * a10);
            o.is_singular = (sy < longint'(thr));
            o.angle_y = 16'(cordic_atan2(-longint'(m.r20), sy));
            if (!o.is_singular)
            begin
                o.angle_x = 16'(cordic_atan2(m.r21, m.r22));
                o.angle_z = 16'(cordic_atan2(m.r10, m.r00));
            end
            else
            begin
                o.angle_x = 16'(cordic_atan2(-longint'(m.r12), m.r11));
                o.angle_z = '0;
            end
            return o;
        end
    endfunction

    function automatic logic signed [15:0] rand_elem();
        int sel;
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                return 16'($urandom);
            if (sel == 1)
                return 16'sd16384;
            if (sel == 2)
                return -16'sd16384;
            if (sel < 6)
                return 16'($signed($urandom_range(0, 400)) - 200);
            return 16'($signed($urandom_range(0, 32768)) - 16384);
        end
    endfunction

    function automatic r2e_in_t rand_matrix();
        r2e_in_t m;
        begin
            m.r00 = rand_elem();
            m.r10 = rand_elem();
            m.r20 = rand_elem();
            m.r21 = rand_elem();
            m.r22 = rand_elem();
            m.r11 = rand_elem();
            m.r12 = rand_elem();
            // near gimbal lock now and then
            if ($urandom_range(0, 5) == 0)
            begin
                m.r00 = 16'($signed($urandom_range(0, 60)) - 30);
                m.r10 = 16'($signed($urandom_range(0, 60)) - 30);
            end
            return m;
        end
    endfunction

    // Driver: bursts and gaps, prediction at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            in_data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                angles_q.push_back(predict_angles(in_data, threshold));
            if (!(start && busy))
            begin
                if (driving_on && matrix_q.size() != 0 && gap_left == 0)
                begin
                    in_data <= matrix_q.pop_front();
                    start <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                begin
                    start <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
            end
        end
    end

    // Monitor: compare each transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (angles_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                errors++;
            end
            else
            begin
                r2e_out_t exp_o;
                exp_o = angles_q.pop_front();
                n_checked++;
                if (exp_o.is_singular)
                    n_singular++;
                if (out_data.angle_x !== exp_o.angle_x)
                begin
                    $display("%0t: angle_x expected %0d got %0d", $time,
                             exp_o.angle_x, out_data.angle_x);
                    errors++;
                end
                if (out_data.angle_y !== exp_o.angle_y)
                begin
                    $display("%0t: angle_y expected %0d got %0d", $time,
                             exp_o.angle_y, out_data.angle_y);
                    errors++;
                end
                if (out_data.angle_z !== exp_o.angle_z)
                begin
                    $display("%0t: angle_z expected %0d got %0d", $time,
                             exp_o.angle_z, out_data.angle_z);
                    errors++;
                end
                if (out_data.is_singular !== exp_o.is_singular)
                begin
                    $display("%0t: is_singular expected %0b got %0b", $time,
                             exp_o.is_singular, out_data.is_singular);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        begin
            driving_on = 1'b1;
            while (matrix_q.size() != 0 || start)
                @(posedge clk);
            while (angles_q.size() != 0)
                @(posedge clk);
            driving_on = 1'b0;
            repeat (LATENCY) @(posedge clk);
        end
    endtask

    task automatic write_threshold(logic [14:0] v);
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= v;
            threshold = v;
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic add_matrix(int a, int b, int c, int d, int e, int f, int g);
        r2e_in_t m;
        begin
            m = {16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g)};
            matrix_q.push_back(m);
        end
    endtask

    initial
    begin
        logic [14:0] thr_list[5];
        errors = 0;
        n_checked = 0;
        n_singular = 0;
        driving_on = 1'b0;
        threshold = 15'd1;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        start = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, axes, zero vectors, extremes, odd bit patterns
        add_matrix(16384, 0, 0, 0, 16384, 16384, 0);
        add_matrix(0, 0, 0, 0, 0, 0, 0);
        add_matrix(0, 0, 16384, 0, 0, 16384, 0);
        add_matrix(0, 0, -16384, 0, 0, 0, 16384);
        add_matrix(-16384, 0, 0, 0, -16384, -16384, 0);
        add_matrix(-16384, -1, 0, -1, -16384, 0, 0);
        add_matrix(-16384, 1, 1, 1, -16384, 0, 0);
        add_matrix(0, 16384, 0, 16384, 0, 0, -16384);
        add_matrix(0, -16384, 0, -16384, 0, 0, 0);
        add_matrix(11585, 11585, -11585, 11585, 11585, 0, 0);
        add_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_matrix(-32768, 32767, 32767, -32768, 32767, -32768, 32767);
        add_matrix(1, 0, 0, 0, 1, 0, 0);
        add_matrix(-1, 0, 0, 0, -1, -1, 0);
        add_matrix(16384, -16384, 16384, -16384, 16384, -16384, 16384);
        drain();

        // Corner cases under a large threshold, then random under several settings
        thr_list = '{15'd16384, 15'd0, 15'd32767, 15'd200, 15'd1};
        write_threshold(15'd16384);
        add_matrix(0, 0, 16384, 0, 0, 16384, 0);
        add_matrix(0, 0, 0, 0, 0, -16384, 16384);
        add_matrix(100, 100, 0, 5, 5, 0, -16384);
        add_matrix(0, 0, 0, 0, 0, 0, 0);
        drain();
        foreach (thr_list[k])
        begin
            write_threshold(thr_list[k]);
            for (int i = 0; i < N_RANDOM / 5; i++)
                matrix_q.push_back(rand_matrix());
            drain();
        end

        $display("Checked %0d results, %0d of them in gimbal lock, over %0d threshold settings.",
                 n_checked, n_singular, 7);
        if (errors == 0)
            $display("[rotation_to_euler_angles] OK");
        else
            $display("[rotation_to_euler_angles] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[rotation_to_euler_angles] ERROR");
        $finish;
    end

endmodule
